@@ hdl/fisr_pkg.sv @@
// fisr_pkg: constants and shared single-precision helpers for the
// reciprocal square root pipeline; no dependencies
`default_nettype none
package fisr_pkg;

    localparam logic [31:0] MAGIC_SEED     = 32'h5f3759df;
    localparam logic [31:0] FP_HALF        = 32'h3f000000;
    localparam logic [31:0] FP_THREE_HALF  = 32'h3fc00000;
    localparam logic [31:0] FP_DEFAULT_NAN = 32'hffc00000;
    localparam logic [31:0] FP_QUIET_BIT   = 32'h00400000;
    localparam int          PIPE_DEPTH     = 10;
    localparam int          SEED_DELAY     = 8;

    // position of the most significant set bit, zero when none
    function automatic logic [5:0] lead_one48(input logic [47:0] v);
        logic [5:0] idx;
        idx = 6'd0;
        for (int i = 0; i < 48; i++) begin
            if (v[i]) idx = 6'(i);
        end
        return idx;
    endfunction

    // round to nearest even and pack; q has its leading one at bit 47,
    // e is the biased exponent of that leading one
    function automatic logic [31:0] round_pack(input logic s,
                                               input logic signed [11:0] e,
                                               input logic [47:0] q);
        logic [5:0]  d;
        logic [47:0] sh;
        logic [47:0] lost_mask;
        logic        lost;
        logic [23:0] m;
        logic        g;
        logic        st;
        logic        inc;
        logic [24:0] mr;
        logic [7:0]  base;
        logic [31:0] mag;
        logic [31:0] r;
        if (e >= 12'sd255) begin
            r = {s, 8'hff, 23'd0};
        end else begin
            if (e < 12'sd1) begin
                d = (e < -12'sd47) ? 6'd48 : 6'(12'sd1 - e);
            end else begin
                d = 6'd0;
            end
            sh        = q >> d;
            lost_mask = (48'd1 << d) - 48'd1;
            lost      = |(q & lost_mask);
            m         = sh[47:24];
            g         = sh[23];
            st        = (|sh[22:0]) | lost;
            inc       = g & (st | m[0]);
            mr        = {1'b0, m} + {24'd0, inc};
            base      = (e < 12'sd1) ? 8'd0 : 8'(e - 12'sd1);
            // carry out of the mantissa bumps the exponent field
            mag       = {1'b0, base, 23'd0} + {7'd0, mr};
            r         = {s, mag[30:0]};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

@@ hdl/fisr_fmul.sv @@
// fisr_fmul: two-stage single-precision multiplier, round to nearest even
// depends on fisr_pkg
`default_nettype none
module fisr_fmul
    import fisr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic [31:0] i_a,
    input  wire logic [31:0] i_b,
    output logic      [31:0] o_p
);

    logic [7:0]  ea, eb;
    logic [22:0] fa, fb;
    logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    logic        sgn;
    logic        n_spec;
    logic [31:0] n_spec_val;
    logic [23:0] ma, mb;
    logic [7:0]  xa, xb;

    logic        r_spec;
    logic [31:0] r_spec_val;
    logic [47:0] r_prod;
    logic signed [11:0] r_es;
    logic        r_sgn;

    logic [5:0]  lead;
    logic [47:0] norm;
    logic signed [11:0] exp_n;
    logic [31:0] n_p;
    logic [31:0] r_p;

    always_comb begin
        ea     = i_a[30:23];
        eb     = i_b[30:23];
        fa     = i_a[22:0];
        fb     = i_b[22:0];
        a_nan  = (ea == 8'hff) && (fa != 23'd0);
        b_nan  = (eb == 8'hff) && (fb != 23'd0);
        a_inf  = (ea == 8'hff) && (fa == 23'd0);
        b_inf  = (eb == 8'hff) && (fb == 23'd0);
        a_zero = (ea == 8'd0) && (fa == 23'd0);
        b_zero = (eb == 8'd0) && (fb == 23'd0);
        sgn    = i_a[31] ^ i_b[31];
        ma     = {ea != 8'd0, fa};
        mb     = {eb != 8'd0, fb};
        xa     = (ea == 8'd0) ? 8'd1 : ea;
        xb     = (eb == 8'd0) ? 8'd1 : eb;
        n_spec = 1'b1;
        if (a_nan) begin
            n_spec_val = i_a | FP_QUIET_BIT;
        end else if (b_nan) begin
            n_spec_val = i_b | FP_QUIET_BIT;
        end else if ((a_inf && b_zero) || (b_inf && a_zero)) begin
            n_spec_val = FP_DEFAULT_NAN;
        end else if (a_inf || b_inf) begin
            n_spec_val = {sgn, 8'hff, 23'd0};
        end else if (a_zero || b_zero) begin
            n_spec_val = {sgn, 31'd0};
        end else begin
            n_spec     = 1'b0;
            n_spec_val = 32'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_spec     <= n_spec;
            r_spec_val <= n_spec_val;
            r_prod     <= 48'(ma) * 48'(mb);
            r_es       <= 12'(signed'({4'd0, xa})) + 12'(signed'({4'd0, xb})) - 12'sd127;
            r_sgn      <= sgn;
        end
    end

    always_comb begin
        lead  = lead_one48(r_prod);
        norm  = r_prod << (6'd47 - lead);
        exp_n = r_es + 12'(signed'({6'd0, lead})) - 12'sd46;
        n_p   = r_spec ? r_spec_val : round_pack(r_sgn, exp_n, norm);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= n_p;
        end
    end

    assign o_p = r_p;

endmodule
`default_nettype wire

@@ hdl/fisr_fadd.sv @@
// fisr_fadd: two-stage single-precision adder, round to nearest even
// depends on fisr_pkg
`default_nettype none
module fisr_fadd
    import fisr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic [31:0] i_a,
    input  wire logic [31:0] i_b,
    output logic      [31:0] o_s
);

    logic [7:0]  ea, eb;
    logic [22:0] fa, fb;
    logic        a_nan, b_nan, a_inf, b_inf;
    logic        n_spec;
    logic [31:0] n_spec_val;
    logic        a_big;
    logic [31:0] big, sml;
    logic [7:0]  xbig, xsml;
    logic [26:0] mx, my, my_sh;
    logic [7:0]  exp_gap;
    logic        y_lost;
    logic [27:0] n_sum;

    logic        r_spec;
    logic [31:0] r_spec_val;
    logic [27:0] r_sum;
    logic [7:0]  r_exp;
    logic        r_sgn;
    logic        r_zsgn;

    logic [47:0] ext;
    logic [5:0]  lead;
    logic [47:0] norm;
    logic signed [11:0] exp_n;
    logic [31:0] n_s;
    logic [31:0] r_s;

    always_comb begin
        ea    = i_a[30:23];
        eb    = i_b[30:23];
        fa    = i_a[22:0];
        fb    = i_b[22:0];
        a_nan = (ea == 8'hff) && (fa != 23'd0);
        b_nan = (eb == 8'hff) && (fb != 23'd0);
        a_inf = (ea == 8'hff) && (fa == 23'd0);
        b_inf = (eb == 8'hff) && (fb == 23'd0);
        n_spec = 1'b1;
        if (a_nan) begin
            n_spec_val = i_a | FP_QUIET_BIT;
        end else if (b_nan) begin
            n_spec_val = i_b | FP_QUIET_BIT;
        end else if (a_inf && b_inf && (i_a[31] != i_b[31])) begin
            n_spec_val = FP_DEFAULT_NAN;
        end else if (a_inf) begin
            n_spec_val = i_a;
        end else if (b_inf) begin
            n_spec_val = i_b;
        end else begin
            n_spec     = 1'b0;
            n_spec_val = 32'd0;
        end

        a_big   = (i_a[30:0] >= i_b[30:0]);
        big     = a_big ? i_a : i_b;
        sml     = a_big ? i_b : i_a;
        xbig    = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
        xsml    = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
        mx      = {big[30:23] != 8'd0, big[22:0], 3'd0};
        my      = {sml[30:23] != 8'd0, sml[22:0], 3'd0};
        exp_gap = xbig - xsml;
        // smaller operand aligned, shifted-out bits fold into sticky
        if (exp_gap >= 8'd27) begin
            my_sh  = 27'd0;
            y_lost = |my;
        end else begin
            my_sh  = my >> exp_gap;
            y_lost = |(my & ((27'd1 << exp_gap) - 27'd1));
        end
        my_sh[0] = my_sh[0] | y_lost;
        if (big[31] != sml[31]) begin
            n_sum = {1'b0, mx} - {1'b0, my_sh};
        end else begin
            n_sum = {1'b0, mx} + {1'b0, my_sh};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_spec     <= n_spec;
            r_spec_val <= n_spec_val;
            r_sum      <= n_sum;
            r_exp      <= xbig;
            r_sgn      <= big[31];
            r_zsgn     <= i_a[31] & i_b[31];
        end
    end

    always_comb begin
        ext   = {r_sum, 20'd0};
        lead  = lead_one48(ext);
        norm  = ext << (6'd47 - lead);
        exp_n = 12'(signed'({4'd0, r_exp})) + 12'(signed'({6'd0, lead})) - 12'sd46;
        if (r_spec) begin
            n_s = r_spec_val;
        end else if (r_sum == 28'd0) begin
            n_s = {r_zsgn, 31'd0};
        end else begin
            n_s = round_pack(r_sgn, exp_n, norm);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s <= n_s;
        end
    end

    assign o_s = r_s;

endmodule
`default_nettype wire

@@ hdl/fast_inverse_square_root.sv @@
// fast_inverse_square_root: top level of the approximate 1/sqrt pipeline
// depends on fisr_pkg, fisr_fmul, fisr_fadd
//
// usage
//   input channel: i_valid, i_operand_bits (single-precision bits), o_stall
//   output channel: o_valid, o_result_bits (single-precision bits), i_stall
//   a word is taken at a clock edge where valid is high and stall is low
//   the seed is the magic constant minus the pattern shifted right by one,
//   then one newton step y*(1.5 - half*y*y), each operation rounded to
//   nearest even
//   throughput: one word per cycle unless stalled; five float units of two
//   stages each (four multipliers and one adder) set the depth
//   when the receiver stalls with a result waiting, the whole pipeline
//   holds and o_stall is raised; nothing is dropped or repeated
//   reset (synchronous, active low) clears the valid bits only
`default_nettype none
module fast_inverse_square_root
    import fisr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [31:0] i_operand_bits,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic      [31:0] o_result_bits
);

    logic                  en;
    logic [PIPE_DEPTH-1:0] r_v;
    logic [31:0]           r_y [SEED_DELAY];
    logic [31:0]           n_seed;
    logic [31:0]           half, t, sq, corr, res;
    logic [31:0]           neg_sq;

    assign en      = ~(r_v[PIPE_DEPTH-1] & i_stall);
    assign o_stall = ~en;

    // arithmetic shift right by one, then subtract from the magic constant
    assign n_seed = MAGIC_SEED - {i_operand_bits[31], i_operand_bits[31:1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[PIPE_DEPTH-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_y[0] <= n_seed;
            for (int i = 1; i < SEED_DELAY; i++) begin
                r_y[i] <= r_y[i-1];
            end
        end
    end

    fisr_fmul u_mul_half (
        .i_clk (i_clk),
        .i_en  (en),
        .i_a   (i_operand_bits),
        .i_b   (FP_HALF),
        .o_p   (half)
    );

    fisr_fmul u_mul_t (
        .i_clk (i_clk),
        .i_en  (en),
        .i_a   (half),
        .i_b   (r_y[1]),
        .o_p   (t)
    );

    fisr_fmul u_mul_sq (
        .i_clk (i_clk),
        .i_en  (en),
        .i_a   (t),
        .i_b   (r_y[3]),
        .o_p   (sq)
    );

    // a nan keeps its sign through the subtraction
    assign neg_sq = ((sq[30:23] == 8'hff) && (sq[22:0] != 23'd0)) ? sq
                                                                  : {~sq[31], sq[30:0]};

    // 1.5 - sq as an add with the sign of sq flipped
    fisr_fadd u_sub_corr (
        .i_clk (i_clk),
        .i_en  (en),
        .i_a   (FP_THREE_HALF),
        .i_b   (neg_sq),
        .o_s   (corr)
    );

    fisr_fmul u_mul_res (
        .i_clk (i_clk),
        .i_en  (en),
        .i_a   (r_y[SEED_DELAY-1]),
        .i_b   (corr),
        .o_p   (res)
    );

    assign o_valid       = r_v[PIPE_DEPTH-1];
    assign o_result_bits = res;

endmodule
`default_nettype wire
